// ===== hdl/mccd_pkg.sv =====
package mccd_pkg;

  localparam int NUM_SLOTS  = 8;
  localparam int SLOT_IDX_W = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int VAL_W      = 7;
  localparam int ENTRY_W    = 8;
  localparam int FIELD_MAX  = 127;

  typedef logic [2:0] step_t;

  localparam step_t STEP_IDLE  = 3'd0;
  localparam step_t STEP_START = 3'd1;
  localparam step_t STEP_SLOT  = 3'd2;
  localparam step_t STEP_DRAIN = 3'd3;
  localparam step_t STEP_WRITE = 3'd4;
  localparam step_t STEP_READ  = 3'd5;
  localparam step_t STEP_CATCH = 3'd6;
  localparam step_t STEP_EMIT  = 3'd7;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_IN,
    COND_ZERO_OR_OVER,
    COND_SLOT_MORE,
    COND_MORE_I,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    logic  in_ready;
    logic  start;
    logic  issue;
    logic  write_entry;
    logic  read_final;
    logic  catch_res;
    logic  load_out;
    cond_t cond;
    step_t target;
  } ctl_t;

  typedef struct packed {
    logic no_in;
    logic zero_or_over;
    logic slot_more;
    logic more_i;
    logic out_busy;
  } flags_t;

  function automatic ctl_t rom(input step_t step);
    ctl_t w;
    w = '0;
    w.cond = COND_NEVER;
    w.target = STEP_IDLE;
    unique case (step)
      STEP_IDLE: begin
        w.in_ready = 1'b1;
        w.cond     = COND_NO_IN;
        w.target   = STEP_IDLE;
      end
      STEP_START: begin
        w.start  = 1'b1;
        w.cond   = COND_ZERO_OR_OVER;
        w.target = STEP_READ;
      end
      STEP_SLOT: begin
        w.issue  = 1'b1;
        w.cond   = COND_SLOT_MORE;
        w.target = STEP_SLOT;
      end
      STEP_DRAIN: begin
        w.cond = COND_NEVER;
      end
      STEP_WRITE: begin
        w.write_entry = 1'b1;
        w.cond        = COND_MORE_I;
        w.target      = STEP_SLOT;
      end
      STEP_READ: begin
        w.read_final = 1'b1;
      end
      STEP_CATCH: begin
        w.catch_res = 1'b1;
      end
      STEP_EMIT: begin
        w.load_out = 1'b1;
        w.cond     = COND_OUT_BUSY;
        w.target   = STEP_EMIT;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/min_coin_change_dp_unit.sv =====
// channel | signals                          | direction
// input   | in_valid, in_ready, target_amount | in
// output  | out_valid, out_ready, coin_count, reachable | out
// config  | cfg_valid, cfg_ready, cfg_index, cfg_data   | in
//
// a transaction runs start, entries 1 to target_amount, read, catch and emit
// each table entry costs a cost-table read per usable coin plus drain and write
// rst is synchronous; coins reset to 1, 0, 0, ...; cost table is not cleared
// a waiting result is held in the output register while the next item is taken
// output stall only holds the sequencer when a second result is ready
module min_coin_change_dp_unit #(
  parameter int MAX_AMOUNT = 127,
  parameter int NUM_COINS  = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mccd_pkg::VAL_W-1:0]     target_amount,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mccd_pkg::VAL_W-1:0]     coin_count,
  output logic                           reachable,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mccd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mccd_pkg::VAL_W-1:0]     cfg_data
);

  localparam int VW          = mccd_pkg::VAL_W;
  localparam int EW          = mccd_pkg::ENTRY_W;
  localparam int SIW         = mccd_pkg::SLOT_IDX_W;
  localparam int TABLE_DEPTH =
    ((MAX_AMOUNT < mccd_pkg::FIELD_MAX) ? MAX_AMOUNT : mccd_pkg::FIELD_MAX) + 1;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int SLOT_W      = (NUM_COINS > 1) ? $clog2(NUM_COINS) : 1;

  mccd_pkg::ctl_t   ctl;
  mccd_pkg::flags_t flags;

  logic [VW-1:0]     coin_value [mccd_pkg::NUM_SLOTS];
  logic [VW-1:0]     amount;
  logic [VW-1:0]     i;
  logic [SLOT_W-1:0] slot;
  logic              found;
  logic [VW-1:0]     best;
  logic              pend;
  logic [VW-1:0]     res_count;
  logic              res_reach;

  logic [VW-1:0]     coin;
  logic              usable;
  logic              over;
  logic              slot_last;
  logic [VW-1:0]     cand;
  logic              take_cand;
  logic              in_acc;
  logic              out_busy;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [EW-1:0]     ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [EW-1:0]     ram_rdata;

  assign in_ready  = ctl.in_ready;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid & in_ready;
  assign out_busy  = out_valid & ~out_ready;

  assign coin      = coin_value[SIW'(slot)];
  assign usable    = (coin != '0) && (coin <= i);
  assign over      = int'(amount) > MAX_AMOUNT;
  assign slot_last = (slot == SLOT_W'(NUM_COINS - 1));
  assign cand      = ram_rdata[VW-1:0] + VW'(1);
  assign take_cand = pend && ram_rdata[EW-1] && (!found || cand < best);

  assign flags.no_in        = ~in_acc;
  assign flags.zero_or_over = (amount == '0) || over;
  assign flags.slot_more    = ~slot_last;
  assign flags.more_i       = (i != amount);
  assign flags.out_busy     = out_busy;

  assign ram_we    = (ctl.start & ~over) | ctl.write_entry;
  assign ram_waddr = ctl.start ? '0 : ADDR_W'(i);
  assign ram_wdata = ctl.start ? {1'b1, {VW{1'b0}}}
                               : (found ? {1'b1, best} : '0);
  assign ram_re    = (ctl.issue & usable) | ctl.read_final;
  assign ram_raddr = ctl.issue ? ADDR_W'(i - coin) : ADDR_W'(amount);

  mccd_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl)
  );

  mccd_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_cost_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < mccd_pkg::NUM_SLOTS; k++) begin
        coin_value[k] <= (k == 0) ? VW'(1) : '0;
      end
      pend      <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        coin_value[cfg_index] <= cfg_data;
      end

      // previous slot read lands here
      pend <= ctl.issue & usable;

      if (ctl.start || ctl.write_entry) begin
        found <= 1'b0;
      end else if (take_cand) begin
        found <= 1'b1;
      end

      if (ctl.load_out && !out_busy) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      amount <= target_amount;
    end
    if (ctl.start) begin
      i    <= VW'(1);
      slot <= '0;
    end
    if (ctl.issue) begin
      slot <= slot_last ? '0 : SLOT_W'(slot + 1'b1);
    end
    if (ctl.write_entry) begin
      i <= i + VW'(1);
    end
    if (take_cand) begin
      best <= cand;
    end
    if (ctl.catch_res) begin
      res_reach <= ram_rdata[EW-1] & ~over;
      res_count <= (ram_rdata[EW-1] && !over) ? ram_rdata[VW-1:0] : '0;
    end
    if (ctl.load_out && !out_busy) begin
      coin_count <= res_count;
      reachable  <= res_reach;
    end
  end

endmodule

// ===== hdl/mccd_ram.sv =====
module mccd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/mccd_seq.sv =====
module mccd_seq (
  input  logic              clk,
  input  logic              rst,
  input  mccd_pkg::flags_t  flags,
  output mccd_pkg::ctl_t    ctl
);

  mccd_pkg::step_t pc;
  mccd_pkg::step_t pc_next;
  logic            take;

  assign ctl = mccd_pkg::rom(pc);

  always_comb begin
    unique case (ctl.cond)
      mccd_pkg::COND_NEVER:        take = 1'b0;
      mccd_pkg::COND_NO_IN:        take = flags.no_in;
      mccd_pkg::COND_ZERO_OR_OVER: take = flags.zero_or_over;
      mccd_pkg::COND_SLOT_MORE:    take = flags.slot_more;
      mccd_pkg::COND_MORE_I:       take = flags.more_i;
      mccd_pkg::COND_OUT_BUSY:     take = flags.out_busy;
      default:                     take = 1'b0;
    endcase
    pc_next = take ? ctl.target : mccd_pkg::step_t'(pc + 3'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= mccd_pkg::STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== hdl/mccd_chk.sv =====
module mccd_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [mccd_pkg::VAL_W-1:0]     coin_count,
  input logic                           reachable
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(coin_count) && $stable(reachable))
    else $error("output changed while stalled");

  a_unreach_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reachable |-> coin_count == '0)
    else $error("unreachable result with nonzero count");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a transaction is in flight");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared one cycle after accept");

endmodule

bind min_coin_change_dp_unit mccd_chk u_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .coin_count    (coin_count),
  .reachable     (reachable)
);

// ===== test/min_coin_change_dp_unit_test.sv =====
module min_coin_change_dp_unit_test;

  localparam int VAL_W          = mccd_pkg::VAL_W;
  localparam int CFG_IDX_W      = mccd_pkg::CFG_IDX_W;
  localparam int NUM_SLOTS      = mccd_pkg::NUM_SLOTS;
  localparam int ENTRY_W        = mccd_pkg::ENTRY_W;
  localparam int FIELD_MAX      = mccd_pkg::FIELD_MAX;
  localparam int NUM_COINS      = 8;
  localparam int MAX_AMOUNT     = 127;
  localparam int HOLD_CYCLES    = 3000;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 40;
  localparam int IDLE_PCT       = 13;

  typedef struct packed {
    logic [VAL_W-1:0] count;
    logic             reach;
  } change_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [VAL_W-1:0]     target_amount = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [VAL_W-1:0]     coin_count;
  logic                 reachable;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0]     cfg_data = '0;

  logic [VAL_W-1:0] coin_reg [NUM_SLOTS] = '{7'd1, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0};
  logic [VAL_W-1:0] next_coins [NUM_SLOTS];
  change_t          expected_changes [$];
  int               errors = 0;
  bit               no_gaps = 1'b0;
  int               hold_requests = 0;
  int               holds_served = 0;
  int               stall_left = 0;
  int               stalled_cycles = 0;

  min_coin_change_dp_unit #(
    .MAX_AMOUNT(MAX_AMOUNT),
    .NUM_COINS (NUM_COINS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .target_amount(target_amount),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .coin_count   (coin_count),
    .reachable    (reachable),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  // bottom-up fewest-coins table, bit 7 marks a reachable entry
  function automatic change_t fewest_coins(input logic [VAL_W-1:0] amount);
    logic [ENTRY_W-1:0] tbl [0:FIELD_MAX];
    change_t            r;
    int                 c;
    int                 cand;
    int                 best;
    bit                 hit;
    tbl[0] = 8'h80;
    for (int i = 1; i <= int'(amount); i++) begin
      hit  = 1'b0;
      best = 0;
      for (int s = 0; s < NUM_SLOTS && s < NUM_COINS; s++) begin
        c = int'(coin_reg[s]);
        if (c != 0 && c <= i && tbl[i - c][7]) begin
          cand = int'(tbl[i - c][6:0]) + 1;
          if (!hit || cand < best) begin
            best = cand;
            hit  = 1'b1;
          end
        end
      end
      tbl[i] = hit ? {1'b1, 7'(best)} : 8'h00;
    end
    r.reach = tbl[amount][7];
    r.count = tbl[amount][7] ? tbl[amount][6:0] : '0;
    return r;
  endfunction

  task automatic check_change();
    change_t exp_c;
    if (expected_changes.size() == 0) begin
      $error("unexpected result: coin_count %0d reachable %0d", coin_count, reachable);
      errors++;
    end else begin
      exp_c = expected_changes.pop_front();
      if (coin_count !== exp_c.count) begin
        $error("coin_count: expected %0d, got %0d", exp_c.count, coin_count);
        errors++;
      end
      if (reachable !== exp_c.reach) begin
        $error("reachable: expected %0d, got %0d", exp_c.reach, reachable);
        errors++;
      end
    end
  endtask

  // receiver side, with random stalls and requested long hold-offs
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_change();
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      stall_left   <= HOLD_CYCLES;
      out_ready    <= 1'b0;
    end else begin
      out_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  task automatic offer_amount(input logic [VAL_W-1:0] amount);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    target_amount <= amount;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_changes.push_back(fewest_coins(amount));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_changes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_coins();
    wait_drained();
    for (int s = 0; s < NUM_SLOTS; s++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(s);
      cfg_data  <= next_coins[s];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      coin_reg[s] = next_coins[s];
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_coins();
    offer_amount(7'd0);
    offer_amount(7'd1);
    offer_amount(7'd127);
    offer_amount(7'd64);
  endtask

  task automatic test_all_slots_unused();
    next_coins = '{7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0};
    apply_coins();
    offer_amount(7'd0);
    offer_amount(7'd1);
    offer_amount(7'd127);
  endtask

  task automatic test_largest_coins();
    next_coins = '{7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127};
    apply_coins();
    offer_amount(7'd127);
    offer_amount(7'd126);
    offer_amount(7'd0);
  endtask

  task automatic test_sparse_slots();
    next_coins = '{7'd0, 7'd0, 7'd0, 7'd5, 7'd0, 7'd7, 7'd0, 7'd0};
    apply_coins();
    offer_amount(7'd1);
    offer_amount(7'd5);
    offer_amount(7'd12);
    offer_amount(7'd23);
    offer_amount(7'd24);
  endtask

  // greedy choice is not optimal for 1, 3, 4
  task automatic test_non_greedy();
    next_coins = '{7'd1, 7'd3, 7'd4, 7'd0, 7'd0, 7'd0, 7'd42, 7'd85};
    apply_coins();
    offer_amount(7'd6);
    offer_amount(7'd85);
    offer_amount(7'd127);
  endtask

  task automatic test_output_backpressure();
    next_coins = '{7'd1, 7'd2, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0};
    apply_coins();
    hold_requests <= hold_requests + 1;
    for (int k = 0; k < 12; k++) offer_amount(7'($urandom_range(8)));
  endtask

  task automatic test_random_queries();
    for (int phase = 0; phase < 7; phase++) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        if ($urandom_range(99) < 30) next_coins[s] = '0;
        else if ($urandom_range(1)) next_coins[s] = 7'($urandom_range(16, 1));
        else next_coins[s] = 7'($urandom_range(127, 1));
      end
      apply_coins();
      no_gaps = (phase == 3);
      for (int k = 0; k < 80; k++) offer_amount(7'($urandom_range(127)));
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_coins();
    test_all_slots_unused();
    test_largest_coins();
    test_sparse_slots();
    test_non_greedy();
    test_output_backpressure();
    test_random_queries();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
